// ----- src/ccs_pkg.sv -----
package ccs_pkg;

  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  // What the back end has to emit for one input item.
  typedef struct packed {
    logic       emit_slash;  // a held slash goes out first
    logic       emit_byte;   // the item's own byte goes out
    logic [7:0] data;
    logic       last;        // end of text; bare marker if nothing is emitted
  } entry_t;

endpackage

// ----- src/ccs_front.sv -----
module ccs_front import ccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [3:0] MODE_NORMAL  = 4'd0;
  localparam logic [3:0] MODE_SLASH   = 4'd1;
  localparam logic [3:0] MODE_LINE    = 4'd2;
  localparam logic [3:0] MODE_BLOCK   = 4'd3;
  localparam logic [3:0] MODE_BSTAR   = 4'd4;
  localparam logic [3:0] MODE_STR     = 4'd5;
  localparam logic [3:0] MODE_STR_ESC = 4'd6;
  localparam logic [3:0] MODE_CHR     = 4'd7;
  localparam logic [3:0] MODE_CHR_ESC = 4'd8;

  logic [3:0] mode;
  logic [3:0] mode_next;
  logic       norm_hold;
  logic [3:0] norm_mode;
  logic [3:0] lit_mode;
  logic       in_chr;
  logic       escaped;
  entry_t     e;

  // Normal-text handling, shared by normal mode and a released slash.
  always_comb begin
    norm_hold = (in_byte == CHAR_SLASH) && !in_last;
    if (norm_hold) begin
      norm_mode = MODE_SLASH;
    end else if (in_byte == CHAR_DQUOTE) begin
      norm_mode = MODE_STR;
    end else if (in_byte == CHAR_SQUOTE) begin
      norm_mode = MODE_CHR;
    end else begin
      norm_mode = MODE_NORMAL;
    end
  end

  // Literal handling; a newline always closes the literal.
  always_comb begin
    in_chr  = (mode == MODE_CHR) || (mode == MODE_CHR_ESC);
    escaped = (mode == MODE_STR_ESC) || (mode == MODE_CHR_ESC);
    if (in_byte == CHAR_NL) begin
      lit_mode = MODE_NORMAL;
    end else if (escaped) begin
      lit_mode = in_chr ? MODE_CHR : MODE_STR;
    end else if (in_byte == CHAR_BSLASH) begin
      lit_mode = in_chr ? MODE_CHR_ESC : MODE_STR_ESC;
    end else if (in_byte == (in_chr ? CHAR_SQUOTE : CHAR_DQUOTE)) begin
      lit_mode = MODE_NORMAL;
    end else begin
      lit_mode = in_chr ? MODE_CHR : MODE_STR;
    end
  end

  always_comb begin
    mode_next    = mode;
    e.emit_slash = 1'b0;
    e.emit_byte  = 1'b0;
    e.data       = in_byte;
    e.last       = in_last;
    case (mode)
      MODE_SLASH: begin
        if (in_byte == CHAR_SLASH) begin
          mode_next = MODE_LINE;
        end else if (in_byte == CHAR_STAR) begin
          mode_next = MODE_BLOCK;
        end else begin
          e.emit_slash = 1'b1;
          e.emit_byte  = !norm_hold;
          mode_next    = norm_mode;
        end
      end
      MODE_LINE: begin
        if (in_byte == CHAR_NL) begin
          e.emit_byte = 1'b1;
          mode_next   = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (in_byte == CHAR_STAR) begin
          mode_next = MODE_BSTAR;
        end
      end
      MODE_BSTAR: begin
        if (in_byte == CHAR_SLASH) begin
          mode_next = MODE_NORMAL;
        end else if (in_byte != CHAR_STAR) begin
          mode_next = MODE_BLOCK;
        end
      end
      MODE_STR, MODE_STR_ESC, MODE_CHR, MODE_CHR_ESC: begin
        e.emit_byte = 1'b1;
        mode_next   = lit_mode;
      end
      default: begin
        e.emit_byte = !norm_hold;
        mode_next   = norm_mode;
      end
    endcase
    if (in_last) begin
      mode_next = MODE_NORMAL;
    end
  end

  assign push       = accept && (e.emit_slash || e.emit_byte || e.last);
  assign push_entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

// ----- src/ccs_queue.sv -----
module ccs_queue import ccs_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push && !full) - CntW'(pop && !empty);
    end
  end

endmodule

// ----- src/ccs_back.sv -----
module ccs_back import ccs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       empty,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  logic       second;  // the held slash of the head item has gone out
  logic       load;
  logic       slash_now;
  logic [7:0] res_byte;
  logic       res_valid;
  logic       res_last;

  assign load      = !empty && (!out_tvalid || out_tready);
  assign slash_now = head.emit_slash && !second;

  always_comb begin
    if (slash_now) begin
      res_byte  = CHAR_SLASH;
      res_valid = 1'b1;
      res_last  = head.last && !head.emit_byte;
    end else begin
      res_byte  = head.emit_byte ? head.data : 8'h00;
      res_valid = head.emit_byte;
      res_last  = head.last;
    end
  end

  assign pop = load && !(slash_now && head.emit_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
      second     <= 1'b0;
    end else begin
      if (load) begin
        out_tvalid <= 1'b1;
        second     <= slash_now && head.emit_byte;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata <= res_byte;
      out_tuser <= res_valid;
      out_tlast <= res_last;
    end
  end

endmodule

// ----- src/c_comment_stripper.sv -----
// Path: an accepted byte goes into the entry queue, then into the output register; a
// slash is held until the next byte arrives and then, unless the two open a comment,
// leaves just ahead of it. Throughput: one item per cycle while the queue is not
// full; a released slash adds an output beat, which the front-to-back queue absorbs.
// Reset (rst, synchronous) returns the scanner to normal text and empties the queue.
module c_comment_stripper import ccs_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] out_valid
  output logic       out_tlast
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   full;
  logic   empty;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  ccs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  ccs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  ccs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
